// ===== rtl/pet_pkg.sv =====
package pet_pkg;

  localparam int DEF_CHANNELS = 32;
  localparam int MAX_RESULTS  = 32;
  localparam logic [31:0] RESET_PERIOD = 32'd1000;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_STOP   = 2'd2;
  localparam logic [1:0] REQ_PERIOD = 2'd3;

  // State of one timer channel as it travels around the ring.
  typedef struct packed {
    logic        running;
    logic [31:0] period;
    logic [31:0] countdown;
    logic [31:0] limit;
    logic [31:0] stage;
  } rec_t;

  // A channel command broadcast to every cell.
  typedef struct packed {
    logic        valid;
    logic [1:0]  req;
    logic [5:0]  chan;
    logic [31:0] period;
    logic [31:0] limit;
    logic [31:0] stage;
  } cmd_t;

  // A stored period of zero behaves as one tick.
  function automatic logic [31:0] eff_period(input logic [31:0] p);
    return (p == 32'd0) ? 32'd1 : p;
  endfunction

endpackage

// ===== rtl/pet_cell.sv =====
module pet_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  pet_pkg::rec_t rec_in,
  input  pet_pkg::cmd_t cmd,
  output pet_pkg::rec_t rec_out
);

  pet_pkg::rec_t rec_r;
  pet_pkg::rec_t rec_nxt;
  logic [31:0]   new_period;

  assign rec_out = rec_r;

  always_comb begin
    rec_nxt    = rec_r;
    new_period = (cmd.period != 32'd0) ? cmd.period : rec_r.period;
    if (shift_en) begin
      rec_nxt = rec_in;
    end else if (cmd.valid && cmd.chan == 6'(IDX)) begin
      case (cmd.req)
        pet_pkg::REQ_START: begin
          rec_nxt.period    = new_period;
          rec_nxt.countdown = pet_pkg::eff_period(new_period);
          rec_nxt.limit     = cmd.limit;
          rec_nxt.stage     = cmd.stage;
          rec_nxt.running   = 1'b1;
        end
        pet_pkg::REQ_STOP:   rec_nxt.running = 1'b0;
        pet_pkg::REQ_PERIOD: rec_nxt.period  = cmd.period;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.running   <= 1'b0;
      rec_r.period    <= pet_pkg::RESET_PERIOD;
      rec_r.countdown <= 32'd0;
      rec_r.limit     <= 32'd0;
      rec_r.stage     <= 32'd0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

endmodule

// ===== rtl/pet_update.sv =====
module pet_update (
  input  pet_pkg::rec_t rec_in,
  output pet_pkg::rec_t rec_out,
  output logic          fire
);

  always_comb begin
    rec_out = rec_in;
    fire    = 1'b0;
    if (rec_in.running) begin
      if (rec_in.countdown > 32'd1) begin
        rec_out.countdown = rec_in.countdown - 32'd1;
      end else begin
        rec_out.countdown = pet_pkg::eff_period(rec_in.period);
        if (rec_in.limit != 32'd0 && rec_in.stage >= rec_in.limit) begin
          rec_out.running = 1'b0;
        end else begin
          fire = 1'b1;
          if (rec_in.stage != 32'hFFFF_FFFF) begin
            rec_out.stage = rec_in.stage + 32'd1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/periodic_event_timer_bank.sv =====
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   req_type, channel, period_ticks,
//                                           repeat_limit, start_stage
// out      output     out_valid / out_ready event_channel, event_stage, last
//
// A start, stop or set-period beat is taken while idle and lands directly
// in the addressed cell. After a tick beat is accepted, in_ready stays low
// while the ring makes one rotation step per channel and the final held
// event is released. A step that would displace a held event stalls while
// out_ready holds back a waiting event, and the release of the final event
// also waits until the output register is free.
// Reset is synchronous and active low and returns every channel to stopped
// with a period of 1000 ticks. in_ready is low for the whole tick scan.

module periodic_event_timer_bank #(
  parameter int CHANNELS = pet_pkg::DEF_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_channel,
  input  logic [31:0] in_period_ticks,
  input  logic [31:0] in_repeat_limit,
  input  logic [31:0] in_start_stage,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_event_channel,
  output logic [31:0] out_event_stage,
  output logic        out_last
);

  // The scan counter must hold CHANNELS itself in the general case.
  localparam int CW = $clog2(CHANNELS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t        state_r;
  logic [CW-1:0] scan_r;
  logic [5:0]    n_r;
  logic          pend_v_r;
  logic [5:0]    pend_chan_r;
  logic [31:0]   pend_stage_r;
  logic          out_valid_r;
  logic [5:0]    out_chan_r;
  logic [31:0]   out_stage_r;
  logic          out_last_r;

  pet_pkg::rec_t ring [CHANNELS];
  pet_pkg::rec_t upd_rec;
  pet_pkg::cmd_t cmd;
  logic          fire;
  logic          fire_emit;
  logic          out_free;
  logic          step_ok;
  logic          shift_en;
  logic          push;
  logic          in_fire;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Commands are broadcast; only the cell whose index matches acts on them,
  // so a channel beyond the bank is ignored without any extra check.
  assign cmd.valid  = in_fire && (in_req_type != pet_pkg::REQ_TICK);
  assign cmd.req    = in_req_type;
  assign cmd.chan   = in_channel;
  assign cmd.period = in_period_ticks;
  assign cmd.limit  = in_repeat_limit;
  assign cmd.stage  = in_start_stage;

  // The ring rotates toward cell 0. During a scan, cell 0 holds the channel
  // whose index equals the scan counter, and its updated record re-enters the
  // ring at the far end. After CHANNELS steps every record is home again.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    pet_pkg::rec_t rec_src;
    if (i == CHANNELS - 1) begin : g_tail
      assign rec_src = upd_rec;
    end else begin : g_mid
      assign rec_src = ring[i+1];
    end
    pet_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .rec_in   (rec_src),
      .cmd      (cmd),
      .rec_out  (ring[i])
    );
  end

  pet_update u_update (
    .rec_in  (ring[0]),
    .rec_out (upd_rec),
    .fire    (fire)
  );

  // Only the first MAX_RESULTS events of one tick are reported; the
  // channel state is updated either way.
  assign fire_emit = fire && (n_r < 6'(pet_pkg::MAX_RESULTS));
  assign out_free  = !out_valid_r || out_ready;

  // An event is held back until the next one is found so that the final one
  // of the tick can carry last. A new event can only displace the held one
  // when the output register is free; otherwise the rotation waits.
  assign step_ok  = !(fire_emit && pend_v_r) || out_free;
  assign shift_en = (state_r == ST_SCAN) && step_ok;
  assign push     = (shift_en && fire_emit && pend_v_r) ||
                    ((state_r == ST_FLUSH) && pend_v_r && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_r      <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (push) begin
        out_valid_r <= 1'b1;
        out_chan_r  <= pend_chan_r;
        out_stage_r <= pend_stage_r;
        out_last_r  <= (state_r == ST_FLUSH);
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && in_req_type == pet_pkg::REQ_TICK) begin
            state_r  <= ST_SCAN;
            scan_r   <= '0;
            n_r      <= '0;
            pend_v_r <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (step_ok) begin
            if (fire_emit) begin
              pend_v_r     <= 1'b1;
              pend_chan_r  <= 6'(scan_r);
              pend_stage_r <= ring[0].stage;
              n_r          <= n_r + 6'd1;
            end
            scan_r <= scan_r + CW'(1);
            if (scan_r == CW'(CHANNELS - 1)) begin
              state_r <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            pend_v_r <= 1'b0;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_channel = out_chan_r;
  assign out_event_stage   = out_stage_r;
  assign out_last          = out_last_r;

  // A held event never survives into the idle state.
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("held event left behind after tick scan");

  // The output register is never overwritten while it still holds a beat.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r) |-> out_ready)
    else $error("output beat overwritten before it was taken");

  // A tick beat starts a scan at channel zero.
  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req_type == pet_pkg::REQ_TICK) |=>
      (state_r == ST_SCAN && scan_r == '0 && n_r == '0))
    else $error("tick did not start a scan at channel zero");

  // The event count per tick stays within the report limit.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 6'(pet_pkg::MAX_RESULTS))
    else $error("event count exceeded report limit");

  // The scan counter never runs past the last channel.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r < CW'(CHANNELS)))
    else $error("scan counter beyond bank");

endmodule
